@@ sv/bta8_pkg.sv @@
// Types, constants and the shift-and-add-3 step for the decimal converter.
`default_nettype none

package bta8_pkg;

    localparam int VALUE_W         = 32;
    localparam int NUM_DIGITS      = 8;
    localparam int BCD_W           = NUM_DIGITS * 4;
    localparam int STEPS_PER_STAGE = 4;
    localparam int NUM_STAGES      = VALUE_W / STEPS_PER_STAGE;
    localparam int CHAR_W          = 6;
    localparam int OUT_W           = NUM_DIGITS * CHAR_W;

    // ASCII '0' is 6'b110000, so a digit 0..9 maps to these two high bits over its nibble
    localparam logic [1:0] ASCII_ZERO_HI = 2'b11;
    localparam logic [3:0] DABBLE_LIMIT  = 4'd5;
    localparam logic [3:0] DABBLE_ADD    = 4'd3;

    typedef struct packed {
        logic [VALUE_W-1:0] bin;  // binary bits still to shift in, next bit at the top
        logic [BCD_W-1:0]   bcd;  // eight BCD digits, units in the lowest nibble
    } dabble_t;

    // Run one pipeline stage's worth of double dabble steps
    function automatic dabble_t dabble_stage(input dabble_t cur);
        dabble_t res;
        res = cur;
        for (int s = 0; s < STEPS_PER_STAGE; s++)
        begin
            // correct every digit of five or more before the shift
            for (int d = 0; d < NUM_DIGITS; d++)
            begin
                if (res.bcd[d*4 +: 4] >= DABBLE_LIMIT)
                begin
                    res.bcd[d*4 +: 4] = res.bcd[d*4 +: 4] + DABBLE_ADD;
                end
            end
            // shift the next binary bit into the units digit; carries above the
            // ten-millions digit drop, which gives the value modulo 10^8
            res.bcd = {res.bcd[BCD_W-2:0], res.bin[VALUE_W-1]};
            res.bin = {res.bin[VALUE_W-2:0], 1'b0};
        end
        return res;
    endfunction

endpackage

`default_nettype wire

@@ sv/binary_to_ascii_decimal8.sv @@
// Pipelined binary to eight-digit ASCII decimal converter (top level).
// Takes an unsigned 32-bit value on the slave stream and returns its lowest
// eight decimal digits as ASCII codes '0'..'9' on the master stream, leading
// zeros kept, so the result is the value modulo 100000000. Each transaction in
// gives exactly one transaction out, in order. The conversion is a double
// dabble cut into eight register stages of four shift-and-add-3 steps each:
// a new value is accepted every cycle when the output is not stalled. Each
// stage holds its own valid bit and takes new data whenever it is empty or the
// stage after it moves, so a stalled output only stops the stages that are full
// behind it.
`default_nettype none

module binary_to_ascii_decimal8
    import bta8_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                s_tvalid,
    output      logic                s_tready,
    input  wire logic [VALUE_W-1:0]  s_tdata,   // [31:0] value
    output      logic                m_tvalid,
    input  wire logic                m_tready,
    output      logic [OUT_W-1:0]    m_tdata    // [5:0] digit_7, [11:6] digit_6,
                                                // [17:12] digit_5, [23:18] digit_4,
                                                // [29:24] digit_3, [35:30] digit_2,
                                                // [41:36] digit_1, [47:42] digit_0
);

    logic    valid_reg  [NUM_STAGES];
    logic    valid_next [NUM_STAGES];
    dabble_t stage_reg  [NUM_STAGES];
    dabble_t stage_next [NUM_STAGES];
    logic    stage_ready [NUM_STAGES+1];

    // Work out back-pressure from the output towards the input
    always_comb
    begin
        stage_ready[NUM_STAGES] = m_tready;
        for (int i = NUM_STAGES - 1; i >= 0; i--)
        begin
            stage_ready[i] = !valid_reg[i] || stage_ready[i+1];
        end
    end

    assign s_tready = stage_ready[0];

    // Compute each stage's next contents
    always_comb
    begin
        dabble_t first;
        first.bin = s_tdata;
        first.bcd = '0;
        valid_next[0] = valid_reg[0];
        stage_next[0] = stage_reg[0];
        if (stage_ready[0])
        begin
            valid_next[0] = s_tvalid;
            stage_next[0] = dabble_stage(first);
        end
        for (int i = 1; i < NUM_STAGES; i++)
        begin
            valid_next[i] = valid_reg[i];
            stage_next[i] = stage_reg[i];
            if (stage_ready[i])
            begin
                valid_next[i] = valid_reg[i-1];
                stage_next[i] = dabble_stage(stage_reg[i-1]);
            end
        end
    end

    // Hold the valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_STAGES; i++)
            begin
                valid_reg[i] <= 1'b0;
            end
        end
        else
        begin
            for (int i = 0; i < NUM_STAGES; i++)
            begin
                valid_reg[i] <= valid_next[i];
            end
        end
    end

    // Hold the payload
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < NUM_STAGES; i++)
        begin
            stage_reg[i] <= stage_next[i];
        end
    end

    // Turn the final BCD digits into ASCII, most significant digit first
    assign m_tvalid = valid_reg[NUM_STAGES-1];

    always_comb
    begin
        for (int d = 0; d < NUM_DIGITS; d++)
        begin
            m_tdata[d*CHAR_W +: CHAR_W] =
                {ASCII_ZERO_HI, stage_reg[NUM_STAGES-1].bcd[(NUM_DIGITS-1-d)*4 +: 4]};
        end
    end

    // The input only stalls when a finished result is waiting at the output
    assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> (m_tvalid && !m_tready))
        else $error("input stalled without a waiting result");

    // The lowest and highest digits leaving the block are decimal digits
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (stage_reg[NUM_STAGES-1].bcd[3:0] <= 4'd9
                      && stage_reg[NUM_STAGES-1].bcd[31:28] <= 4'd9))
        else $error("BCD digit out of range at output");

    // A value accepted into an empty first stage shows as valid there next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> valid_reg[0])
        else $error("accepted transaction lost in first stage");

endmodule

`default_nettype wire
